// ----- sv/tcsw_pkg.sv -----
package tcsw_pkg;

    typedef enum logic [2:0] {
        K_PUT_CHAR    = 3'd0,
        K_SCROLL_UP   = 3'd1,
        K_SCROLL_DOWN = 3'd2,
        K_SCROLL_LEFT = 3'd3,
        K_SCROLL_RIGHT = 3'd4,
        K_READ_CELL   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_BUSY
    } t_state;

    typedef enum logic [0:0] {
        CFG_CHAR_COLOR       = 1'b0,
        CFG_BACKGROUND_COLOR = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] char_code;
        logic [7:0] amount;
        logic [4:0] screen_row;
        logic [6:0] screen_col;
    } t_item;

    typedef struct packed {
        logic [6:0] cursor_row;
        logic [6:0] cursor_col;
        logic [6:0] row_offset;
        logic [5:0] col_offset;
    } t_status;

    localparam logic [7:0]  NEWLINE_CODE   = 8'd10;
    localparam logic [15:0] BLANK_ENTRY    = 16'h0720;
    localparam logic [3:0]  CHAR_COLOR_RST = 4'd7;
    localparam logic [3:0]  BG_COLOR_RST   = 4'd0;

endpackage

// ----- sv/tcsw_ram.sv -----
module tcsw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/tcsw_cursor.sv -----
module tcsw_cursor #(
    parameter int STORE_WIDTH   = 128,
    parameter int STORE_HEIGHT  = 128,
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25,
    localparam int DEPTH = STORE_WIDTH * STORE_HEIGHT,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [3:0]       i_cfg_data,
    input  logic             i_acc,
    input  tcsw_pkg::t_item  i_item,
    output logic             o_mem_we,
    output logic             o_mem_re,
    output logic [AW-1:0]    o_mem_addr,
    output logic [15:0]      o_mem_wdata,
    output tcsw_pkg::t_status o_status
);

    localparam int RW     = $clog2(STORE_HEIGHT);
    localparam int CW     = $clog2(STORE_WIDTH);
    localparam int RSW    = ((RW > 8) ? RW : 8) + 1;
    localparam int CSW    = ((CW > 8) ? CW : 8) + 1;
    localparam int IW     = AW + 2;
    localparam int MAX_VR = STORE_HEIGHT - SCREEN_HEIGHT;
    localparam int MAX_VC = STORE_WIDTH - SCREEN_WIDTH;

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_vrow, n_vrow;
    logic [CW-1:0] r_vcol, n_vcol;
    logic [3:0]    r_fg, r_bg;

    logic          nl, col_wrap, row_adv, row_wrap;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;
    logic [RW-1:0] row_put, vrow_base, vrow_put;
    logic [CW-1:0] col_put;
    logic [RSW-1:0] vrow_sum, rrow;
    logic [CSW-1:0] vcol_sum, rcol;
    logic [IW-1:0] wr_idx, rd_idx;
    logic          rd_ok;

    always_comb begin
        nl       = (i_item.char_code == tcsw_pkg::NEWLINE_CODE);
        col_inc  = {1'b0, r_col} + (CW+1)'(1);
        col_wrap = !nl && (col_inc == (CW+1)'(STORE_WIDTH));
        col_put  = (nl || col_wrap) ? '0 : col_inc[CW-1:0];
        row_adv  = nl || col_wrap;
        row_inc  = {1'b0, r_row} + (RW+1)'(1);
        row_wrap = row_adv && (row_inc == (RW+1)'(STORE_HEIGHT));
        row_put  = row_wrap ? '0 : (row_adv ? row_inc[RW-1:0] : r_row);
        vrow_base = row_wrap ? '0 : r_vrow;
        vrow_put = vrow_base;
        if (RSW'(row_put) >= RSW'(vrow_base) + RSW'(SCREEN_HEIGHT)) begin
            vrow_put = RW'(RSW'(row_put) - RSW'(SCREEN_HEIGHT) + RSW'(1));
        end

        vrow_sum = RSW'(r_vrow) + RSW'(i_item.amount);
        vcol_sum = CSW'(r_vcol) + CSW'(i_item.amount);

        wr_idx = IW'(r_row) * IW'(STORE_WIDTH) + IW'(r_col);
        rrow   = RSW'(i_item.screen_row) + RSW'(r_vrow);
        rcol   = CSW'(i_item.screen_col) + CSW'(r_vcol);
        rd_idx = IW'(rrow) * IW'(STORE_WIDTH) + IW'(rcol);
        rd_ok  = (RSW'(i_item.screen_row) < RSW'(SCREEN_HEIGHT))
              && (CSW'(i_item.screen_col) < CSW'(SCREEN_WIDTH))
              && (rd_idx < IW'(DEPTH));
    end

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_vrow = r_vrow;
        n_vcol = r_vcol;
        case (i_item.kind)
            tcsw_pkg::K_PUT_CHAR: begin
                n_row  = row_put;
                n_col  = col_put;
                n_vrow = vrow_put;
            end
            tcsw_pkg::K_SCROLL_UP: begin
                n_vrow = (RSW'(i_item.amount) > RSW'(r_vrow)) ? '0
                       : RW'(RSW'(r_vrow) - RSW'(i_item.amount));
            end
            tcsw_pkg::K_SCROLL_DOWN: begin
                n_vrow = (vrow_sum > RSW'(MAX_VR)) ? RW'(MAX_VR) : RW'(vrow_sum);
            end
            tcsw_pkg::K_SCROLL_LEFT: begin
                n_vcol = (CSW'(i_item.amount) > CSW'(r_vcol)) ? '0
                       : CW'(CSW'(r_vcol) - CSW'(i_item.amount));
            end
            tcsw_pkg::K_SCROLL_RIGHT: begin
                n_vcol = (vcol_sum > CSW'(MAX_VC)) ? CW'(MAX_VC) : CW'(vcol_sum);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_vrow <= '0;
            r_vcol <= '0;
            r_fg   <= tcsw_pkg::CHAR_COLOR_RST;
            r_bg   <= tcsw_pkg::BG_COLOR_RST;
        end else begin
            if (i_acc) begin
                r_row  <= n_row;
                r_col  <= n_col;
                r_vrow <= n_vrow;
                r_vcol <= n_vcol;
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == tcsw_pkg::CFG_CHAR_COLOR) begin
                    r_fg <= i_cfg_data;
                end else begin
                    r_bg <= i_cfg_data;
                end
            end
        end
    end

    always_comb begin
        o_mem_we    = i_acc && (i_item.kind == tcsw_pkg::K_PUT_CHAR) && !nl;
        o_mem_re    = i_acc && (i_item.kind == tcsw_pkg::K_READ_CELL) && rd_ok;
        o_mem_addr  = o_mem_we ? wr_idx[AW-1:0] : rd_idx[AW-1:0];
        o_mem_wdata = {r_bg, r_fg, i_item.char_code};
        o_status.cursor_row = 7'(r_row);
        o_status.cursor_col = 7'(r_col);
        o_status.row_offset = 7'(r_vrow);
        o_status.col_offset = 6'(r_vcol);
    end

endmodule

// ----- sv/text_console_scrollback_window_unit.sv -----
// Text console with a scrollback store of STORE_HEIGHT x STORE_WIDTH 16-bit cells
// (character low byte, attribute fg | bg << 4 high byte) and a visible window of
// SCREEN_HEIGHT x SCREEN_WIDTH cells. Each item (put char, scroll, read cell) has
// an accept cycle, which updates cursor and window and makes at most one store
// access, and a busy state, which loads the result register with the registered
// read data of the single-port store once the output register is free; a new item
// is accepted only after that load. After reset the store is swept to blank cells
// (0x0720), one cell per cycle, over all STORE_WIDTH*STORE_HEIGHT cells (16384 at
// the defaults); no item is accepted during the sweep, color registers can be written at any time.
module text_console_scrollback_window_unit #(
    parameter int STORE_WIDTH   = 128,
    parameter int STORE_HEIGHT  = 128,
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // char_code[7:0], amount[15:8], screen_row[20:16], screen_col[27:21], zero pad
    input  logic [31:0] i_s_tdata,
    // kind[2:0]
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // cell_entry[15:0], cursor_row[22:16], cursor_col[29:23], row_offset[36:30],
    // col_offset[42:37], zero pad
    output logic [47:0] o_m_tdata
);

    localparam int DEPTH = STORE_WIDTH * STORE_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    tcsw_pkg::t_state  r_state, n_state;
    tcsw_pkg::t_item   item;
    tcsw_pkg::t_status status;

    logic [AW:0]   r_clr_cnt;
    logic          r_cell_sel;
    logic          r_m_valid;
    logic [47:0]   r_m_data;
    logic          acc, load_out, clr_we, clr_last;
    logic          cur_we, cur_re;
    logic [AW-1:0] cur_addr, ram_addr;
    logic [15:0]   cur_wdata, ram_wdata, ram_rdata, cell_data;

    assign item.kind       = i_s_tuser;
    assign item.char_code  = i_s_tdata[7:0];
    assign item.amount     = i_s_tdata[15:8];
    assign item.screen_row = i_s_tdata[20:16];
    assign item.screen_col = i_s_tdata[27:21];

    assign acc      = i_s_tvalid && o_s_tready;
    assign clr_last = (r_clr_cnt == (AW+1)'(DEPTH - 1));

    tcsw_cursor #(
        .STORE_WIDTH   (STORE_WIDTH),
        .STORE_HEIGHT  (STORE_HEIGHT),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (acc),
        .i_item      (item),
        .o_mem_we    (cur_we),
        .o_mem_re    (cur_re),
        .o_mem_addr  (cur_addr),
        .o_mem_wdata (cur_wdata),
        .o_status    (status)
    );

    assign ram_addr  = clr_we ? r_clr_cnt[AW-1:0] : cur_addr;
    assign ram_wdata = clr_we ? tcsw_pkg::BLANK_ENTRY : cur_wdata;

    tcsw_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (clr_we || cur_we),
        .i_re    (cur_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            tcsw_pkg::S_CLEAR: begin
                if (clr_last) begin
                    n_state = tcsw_pkg::S_IDLE;
                end
            end
            tcsw_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = tcsw_pkg::S_BUSY;
                end
            end
            tcsw_pkg::S_BUSY: begin
                if (!r_m_valid || i_m_tready) begin
                    n_state = tcsw_pkg::S_IDLE;
                end
            end
            default: n_state = tcsw_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_s_tready = (r_state == tcsw_pkg::S_IDLE);
        clr_we     = (r_state == tcsw_pkg::S_CLEAR);
        load_out   = (r_state == tcsw_pkg::S_BUSY) && (!r_m_valid || i_m_tready);
    end

    assign cell_data = r_cell_sel ? ram_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tcsw_pkg::S_CLEAR;
            r_clr_cnt  <= '0;
            r_m_valid  <= 1'b0;
            r_cell_sel <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clr_we) begin
                r_clr_cnt <= r_clr_cnt + (AW+1)'(1);
            end
            if (acc) begin
                r_cell_sel <= cur_re;
            end
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_m_data <= {5'd0, status.col_offset, status.row_offset,
                         status.cursor_col, status.cursor_row, cell_data};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcsw_pkg::S_CLEAR) |-> !o_s_tready)
        else $error("item accepted during store sweep");

    a_accept_to_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_state == tcsw_pkg::S_BUSY))
        else $error("accepted item not in flight");

    a_single_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((clr_we || cur_we) && cur_re))
        else $error("store read and write in one cycle");

    a_load_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> $past(acc) || $past(r_state == tcsw_pkg::S_BUSY))
        else $error("result loaded without an item");

endmodule

// ----- dv/text_console_scrollback_window_unit_tb.sv -----
module text_console_scrollback_window_unit_tb;

    localparam int STORE_W      = 128;
    localparam int STORE_H      = 128;
    localparam int SCREEN_W     = 80;
    localparam int SCREEN_H     = 25;
    localparam int MAX_VIEW_ROW = STORE_H - SCREEN_H;
    localparam int MAX_VIEW_COL = STORE_W - SCREEN_W;
    // nothing is accepted during the clearing sweep after reset
    localparam int STALL_LIMIT  = 3 * STORE_W * STORE_H;

    typedef struct {
        logic [15:0] entry;
        logic [6:0]  crow;
        logic [6:0]  ccol;
        logic [6:0]  vrow;
        logic [5:0]  vcol;
    } t_console_out;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [3:0]  i_cfg_data = 4'd0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = 32'd0;
    logic [2:0]  i_s_tuser  = 3'd0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;

    text_console_scrollback_window_unit #(
        .STORE_WIDTH  (STORE_W),
        .STORE_HEIGHT (STORE_H),
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // console shadow state
    logic [15:0]  shadow_cells [0:STORE_W*STORE_H-1];
    int           cursor_row_q;
    int           cursor_col_q;
    int           view_row_q;
    int           view_col_q;
    logic [3:0]   fg_color;
    logic [3:0]   bg_color;

    tcsw_pkg::t_item pending_items [$];
    t_console_out    expected_status [$];
    int           items_sent;
    int           items_taken;
    int           error_count;
    int           stall_cycles;
    bit           steady;
    bit           s_taken;
    bit           m_taken;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int sat_up(input int base, input int amt, input int limit);
        return (base + amt > limit) ? limit : base + amt;
    endfunction

    function automatic t_console_out console_step(input tcsw_pkg::t_item it);
        t_console_out res;
        res.entry = '0;
        case (it.kind)
            tcsw_pkg::K_PUT_CHAR: begin
                if (it.char_code == tcsw_pkg::NEWLINE_CODE) begin
                    cursor_col_q = 0;
                    cursor_row_q++;
                end else begin
                    shadow_cells[cursor_row_q*STORE_W + cursor_col_q] =
                        {bg_color, fg_color, it.char_code};
                    cursor_col_q++;
                    if (cursor_col_q >= STORE_W) begin
                        cursor_col_q = 0;
                        cursor_row_q++;
                    end
                end
                if (cursor_row_q >= STORE_H) begin
                    cursor_row_q = 0;
                    view_row_q   = 0;
                end
                if (cursor_row_q >= view_row_q + SCREEN_H)
                    view_row_q = sat_up(view_row_q, cursor_row_q - view_row_q - SCREEN_H + 1,
                                        MAX_VIEW_ROW);
            end
            tcsw_pkg::K_SCROLL_UP: begin
                view_row_q = (it.amount > view_row_q) ? 0 : view_row_q - it.amount;
            end
            tcsw_pkg::K_SCROLL_DOWN: begin
                view_row_q = sat_up(view_row_q, it.amount, MAX_VIEW_ROW);
            end
            tcsw_pkg::K_SCROLL_LEFT: begin
                view_col_q = (it.amount > view_col_q) ? 0 : view_col_q - it.amount;
            end
            tcsw_pkg::K_SCROLL_RIGHT: begin
                view_col_q = sat_up(view_col_q, it.amount, MAX_VIEW_COL);
            end
            tcsw_pkg::K_READ_CELL: begin
                if (it.screen_row < SCREEN_H && it.screen_col < SCREEN_W)
                    res.entry = shadow_cells[(it.screen_row + view_row_q)*STORE_W
                                             + it.screen_col + view_col_q];
            end
            default: begin
            end
        endcase
        res.crow = cursor_row_q[6:0];
        res.ccol = cursor_col_q[6:0];
        res.vrow = view_row_q[6:0];
        res.vcol = view_col_q[5:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic tcsw_pkg::t_item make_item(input logic [2:0] kind,
                                                  input logic [7:0] code,
                                                  input logic [7:0] amt,
                                                  input logic [4:0] row,
                                                  input logic [6:0] col);
        tcsw_pkg::t_item it;
        it.kind       = kind;
        it.char_code  = code;
        it.amount     = amt;
        it.screen_row = row;
        it.screen_col = col;
        return it;
    endfunction

    // weighted mix; newline_pct shapes line length
    function automatic tcsw_pkg::t_item random_item(input int newline_pct);
        tcsw_pkg::t_item it;
        int    pick;
        it = make_item(3'($urandom_range(7)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 5'($urandom_range(31)),
                       7'($urandom_range(127)));
        pick = $urandom_range(99);
        if (pick < 60) begin
            it.kind = tcsw_pkg::K_PUT_CHAR;
            if ($urandom_range(99) < newline_pct)
                it.char_code = tcsw_pkg::NEWLINE_CODE;
        end else if (pick < 72) begin
            it.kind = 3'($urandom_range(tcsw_pkg::K_SCROLL_RIGHT, tcsw_pkg::K_SCROLL_UP));
            if ($urandom_range(99) < 75)
                it.amount = 8'($urandom_range(30));
        end else if (pick < 97) begin
            it.kind = tcsw_pkg::K_READ_CELL;
            if ($urandom_range(99) < 80) begin
                it.screen_row = 5'($urandom_range(SCREEN_H - 1));
                it.screen_col = 7'($urandom_range(SCREEN_W - 1));
            end
        end else begin
            it.kind = 3'($urandom_range(7, 6));
        end
        return it;
    endfunction

    task automatic send(input tcsw_pkg::t_item it);
        pending_items.push_back(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        while (items_taken != items_sent || expected_status.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= tcsw_pkg::CFG_CHAR_COLOR;
        i_cfg_data <= fg;
        @(negedge i_clk);
        i_cfg_addr <= tcsw_pkg::CFG_BACKGROUND_COLOR;
        i_cfg_data <= bg;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // feed items at the falling edge
    always @(negedge i_clk) begin : feed_driver
        tcsw_pkg::t_item nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_taken) begin
            if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
                nxt = pending_items.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {4'd0, nxt.screen_col, nxt.screen_row, nxt.amount,
                               nxt.char_code};
                i_s_tuser  <= nxt.kind;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        i_m_tready <= steady || $urandom_range(99) >= 34;
    end

    // accept, predict and check at the rising edge
    always @(posedge i_clk) begin : result_monitor
        tcsw_pkg::t_item acc;
        t_console_out    want;
        s_taken = i_rst_n && i_s_tvalid && o_s_tready;
        m_taken = i_rst_n && o_m_tvalid && i_m_tready;
        if (m_taken) begin
            if (expected_status.size() == 0) begin
                $error("result item with nothing expected: %h", o_m_tdata);
                error_count++;
            end else begin
                want = expected_status.pop_front();
                check_field("cell_entry", want.entry, o_m_tdata[15:0]);
                check_field("cursor_row", want.crow, o_m_tdata[22:16]);
                check_field("cursor_col", want.ccol, o_m_tdata[29:23]);
                check_field("row_offset", want.vrow, o_m_tdata[36:30]);
                check_field("col_offset", want.vcol, o_m_tdata[42:37]);
            end
        end
        if (s_taken) begin
            acc = make_item(i_s_tuser, i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[20:16],
                            i_s_tdata[27:21]);
            expected_status.push_back(console_step(acc));
            items_taken++;
        end
        if (i_rst_n && i_cfg_we) begin
            if (i_cfg_addr == tcsw_pkg::CFG_CHAR_COLOR)
                fg_color = i_cfg_data;
            else
                bg_color = i_cfg_data;
        end
        if (s_taken || m_taken || !i_rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < STORE_W*STORE_H; i++)
            shadow_cells[i] = tcsw_pkg::BLANK_ENTRY;
        cursor_row_q = 0;
        cursor_col_q = 0;
        view_row_q   = 0;
        view_col_q   = 0;
        fg_color     = tcsw_pkg::CHAR_COLOR_RST;
        bg_color     = tcsw_pkg::BG_COLOR_RST;
        items_sent   = 0;
        items_taken  = 0;
        error_count  = 0;
        stall_cycles = 0;
        steady       = 1'b0;
        s_taken      = 1'b0;
        m_taken      = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part with reset colors
        send(make_item(tcsw_pkg::K_PUT_CHAR, 8'h41, 8'($urandom_range(255)), 5'd31, 7'd127));
        send(make_item(tcsw_pkg::K_PUT_CHAR, 8'h00, 8'd0, 5'd0, 7'd0));
        send(make_item(tcsw_pkg::K_PUT_CHAR, 8'hFF, 8'd255, 5'd0, 7'd0));
        send(make_item(tcsw_pkg::K_PUT_CHAR, tcsw_pkg::NEWLINE_CODE, 8'd0, 5'd0, 7'd0));
        send(make_item(tcsw_pkg::K_PUT_CHAR, 8'h42, 8'd0, 5'd0, 7'd0));
        send(make_item(tcsw_pkg::K_READ_CELL, 8'hFF, 8'hFF, 5'd0, 7'd0));
        send(make_item(tcsw_pkg::K_READ_CELL, 8'd0, 8'd0, 5'd0, 7'd2));
        send(make_item(tcsw_pkg::K_READ_CELL, 8'd0, 8'd0, 5'd1, 7'd0));
        send(make_item(tcsw_pkg::K_READ_CELL, 8'd0, 8'd0, 5'd24, 7'd79));
        send(make_item(tcsw_pkg::K_READ_CELL, 8'd0, 8'd0, 5'd25, 7'd0));
        send(make_item(tcsw_pkg::K_READ_CELL, 8'd0, 8'd0, 5'd0, 7'd80));
        send(make_item(tcsw_pkg::K_READ_CELL, 8'd0, 8'd0, 5'd31, 7'd127));
        send(make_item(tcsw_pkg::K_SCROLL_DOWN, 8'd0, 8'd255, 5'd0, 7'd0));
        send(make_item(tcsw_pkg::K_READ_CELL, 8'd0, 8'd0, 5'd24, 7'd0));
        send(make_item(tcsw_pkg::K_SCROLL_UP, 8'd0, 8'd255, 5'd0, 7'd0));
        send(make_item(tcsw_pkg::K_SCROLL_DOWN, 8'd0, 8'd0, 5'd0, 7'd0));
        send(make_item(tcsw_pkg::K_SCROLL_UP, 8'd0, 8'd0, 5'd0, 7'd0));
        send(make_item(tcsw_pkg::K_SCROLL_RIGHT, 8'd0, 8'd255, 5'd0, 7'd0));
        send(make_item(tcsw_pkg::K_READ_CELL, 8'd0, 8'd0, 5'd0, 7'd79));
        send(make_item(tcsw_pkg::K_SCROLL_LEFT, 8'd0, 8'd1, 5'd0, 7'd0));
        send(make_item(tcsw_pkg::K_SCROLL_LEFT, 8'd0, 8'd255, 5'd0, 7'd0));
        send(make_item(tcsw_pkg::K_SCROLL_RIGHT, 8'd0, 8'd0, 5'd0, 7'd0));
        send(make_item(3'd6, 8'hFF, 8'hFF, 5'd31, 7'd127));
        send(make_item(3'd7, 8'h00, 8'h00, 5'd0, 7'd0));
        wait_drained();

        // long lines to reach the column wrap
        set_colors(4'd15, 4'd15);
        for (int i = 0; i < 250; i++)
            send(random_item(1));
        wait_drained();

        // newline heavy with no idling, pushes the cursor toward the row wrap
        set_colors(4'd0, 4'd0);
        steady = 1'b1;
        for (int i = 0; i < 250; i++)
            send(random_item(80));
        wait_drained();
        steady = 1'b0;

        set_colors(4'($urandom_range(15)), 4'($urandom_range(15)));
        for (int i = 0; i < 150; i++)
            send(random_item(30));
        wait_drained();
        repeat (20) @(negedge i_clk);

        if (error_count == 0 && expected_status.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/tcsw_pkg.sv
sv/tcsw_ram.sv
sv/tcsw_cursor.sv
sv/text_console_scrollback_window_unit.sv
dv/text_console_scrollback_window_unit_tb.sv
